@@ rtl/core/cbts_pkg.sv @@
// Shared types and constants of the CAN transmit bus-off supervisor.
// No dependencies; the stamp memory, execute stage and top level refer to it by scoped names.
package cbts_pkg;

  localparam logic [2:0] ACT_TICK        = 3'd0;
  localparam logic [2:0] ACT_SEND        = 3'd1;
  localparam logic [2:0] ACT_TX_ACK      = 3'd2;
  localparam logic [2:0] ACT_EVENT_LOST  = 3'd3;
  localparam logic [2:0] ACT_ERR_PASSIVE = 3'd4;
  localparam logic [2:0] ACT_BUS_OFF     = 3'd5;
  localparam logic [2:0] ACT_PROTO_ERR   = 3'd6;
  localparam logic [2:0] ACT_RECOV_FAIL  = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;

  localparam logic [1:0] CFG_BACKOFF_MIN = 2'd0;
  localparam logic [1:0] CFG_BACKOFF_MAX = 2'd1;
  localparam logic [1:0] CFG_RETRY_DELAY = 2'd2;

  localparam logic [15:0] RST_BACKOFF_MIN = 16'd1000;
  localparam logic [15:0] RST_BACKOFF_MAX = 16'd30000;
  localparam logic [15:0] RST_RETRY_DELAY = 16'd100;

  localparam logic [11:0] ID_LIMIT  = 12'h7FF;
  localparam logic [3:0]  LEN_LIMIT = 4'd8;

  localparam int CNT_TX      = 0;
  localparam int CNT_TXERR   = 1;
  localparam int CNT_ACK     = 2;
  localparam int CNT_PROTO   = 3;
  localparam int CNT_PASSIVE = 4;
  localparam int CNT_BUSOFF  = 5;
  localparam int CNT_NUM     = 6;

  typedef struct packed {
    logic [2:0]  action;
    logic [11:0] std_id;
    logic [3:0]  length;
    logic [1:0]  fifo_free;
    logic [7:0]  ack_marker;
  } item_t;

  // The last output field sits in the lowest bits.
  typedef struct packed {
    logic [15:0] backoff_ms;
    logic [31:0] bus_off_count;
    logic [31:0] error_passive_count;
    logic [31:0] protocol_error_count;
    logic [31:0] tx_ack_count;
    logic [31:0] tx_error_count;
    logic [31:0] tx_count;
    logic        recover_now;
    logic [31:0] max_latency_ms;
    logic [31:0] latency_ms;
    logic [7:0]  marker;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic        en;
    logic [7:0]  addr;
    logic [31:0] data;
  } wr_req_t;

endpackage

@@ rtl/core/cbts_stamp_mem.sv @@
// Enqueue time stamp memory, one entry per marker, with per-entry valid bits.
// Registered synchronous read, write-to-read forwarding. Uses cbts_pkg.
module cbts_stamp_mem #(
  parameter int MARKER_COUNT = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [7:0]       rd_marker,
  input  cbts_pkg::wr_req_t wr,
  output logic [31:0]      stamp
);

  localparam int MARK_W = (MARKER_COUNT > 1) ? $clog2(MARKER_COUNT) : 1;

  logic [31:0]             ram [MARKER_COUNT];
  logic [MARKER_COUNT-1:0] vld_r;
  logic [MARK_W-1:0]       mod_tbl [256];
  logic [MARK_W-1:0]       raddr;
  logic [MARK_W-1:0]       waddr;
  logic [31:0]             rd_data_r;
  logic [31:0]             fwd_data_r;
  logic                    rd_vld_r;
  logic                    fwd_r;

  for (genvar gi = 0; gi < 256; gi++) begin : g_mod
    assign mod_tbl[gi] = MARK_W'(gi % MARKER_COUNT);
  end

  assign raddr = mod_tbl[rd_marker];
  assign waddr = wr.addr[MARK_W-1:0];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      ram[waddr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r  <= ram[raddr];
      fwd_data_r <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[waddr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[raddr];
        fwd_r    <= wr.en && (waddr == raddr);
      end
    end
  end

  assign stamp = fwd_r ? fwd_data_r : (rd_vld_r ? rd_data_r : 32'd0);

endmodule

@@ rtl/core/cbts_exec.sv @@
// Execute stage: configuration registers, time base, recovery deadline, backoff,
// marker, peak latency and event counters. Uses cbts_pkg.
module cbts_exec #(
  parameter int MARKER_COUNT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [15:0]         cfg_wdata,
  input  logic                commit,
  input  cbts_pkg::item_t     item,
  input  logic [31:0]         stamp,
  output cbts_pkg::result_t   res,
  output cbts_pkg::wr_req_t   wr
);

  localparam int MARK_W = (MARKER_COUNT > 1) ? $clog2(MARKER_COUNT) : 1;
  localparam logic [MARK_W-1:0] MARK_LAST = MARK_W'(MARKER_COUNT - 1);

  logic [15:0]       backoff_min_r;
  logic [15:0]       backoff_max_r;
  logic [15:0]       retry_delay_r;
  logic [31:0]       now_r,     now_nxt;
  logic              pending_r, pending_nxt;
  logic [31:0]       due_r,     due_nxt;
  logic [15:0]       backoff_r, backoff_nxt;
  logic [MARK_W-1:0] mark_r,    mark_nxt;
  logic [31:0]       peak_r,    peak_nxt;
  logic [31:0]       cnt_r   [cbts_pkg::CNT_NUM];
  logic [31:0]       cnt_nxt [cbts_pkg::CNT_NUM];

  logic [31:0]       now_inc;
  logic [31:0]       diff;
  logic [31:0]       latency;
  logic [16:0]       dbl;
  logic [MARK_W-1:0] mark_inc;

  assign now_inc  = now_r + 32'd1;
  assign diff     = now_inc - due_r;
  assign latency  = now_r - stamp;
  assign dbl      = {backoff_r, 1'b0};
  assign mark_inc = (mark_r == MARK_LAST) ? '0 : mark_r + MARK_W'(1);

  always_comb begin
    now_nxt     = now_r;
    pending_nxt = pending_r;
    due_nxt     = due_r;
    backoff_nxt = backoff_r;
    mark_nxt    = mark_r;
    peak_nxt    = peak_r;
    cnt_nxt     = cnt_r;
    wr          = '0;
    res         = '0;
    case (item.action)
      cbts_pkg::ACT_TICK: begin
        now_nxt = now_inc;
        if (pending_r && !diff[31]) begin
          pending_nxt     = 1'b0;
          res.recover_now = 1'b1;
        end
      end
      cbts_pkg::ACT_SEND: begin
        if (item.std_id > cbts_pkg::ID_LIMIT || item.length > cbts_pkg::LEN_LIMIT) begin
          res.status = cbts_pkg::ST_INVALID;
          cnt_nxt[cbts_pkg::CNT_TXERR] = cnt_r[cbts_pkg::CNT_TXERR] + 32'd1;
        end else if (item.fifo_free == 2'd0) begin
          res.status = cbts_pkg::ST_BUSY;
          cnt_nxt[cbts_pkg::CNT_TXERR] = cnt_r[cbts_pkg::CNT_TXERR] + 32'd1;
        end else begin
          mark_nxt   = mark_inc;
          res.marker = 8'(mark_inc);
          wr.en      = 1'b1;
          wr.addr    = 8'(mark_inc);
          wr.data    = now_r;
          cnt_nxt[cbts_pkg::CNT_TX] = cnt_r[cbts_pkg::CNT_TX] + 32'd1;
        end
      end
      cbts_pkg::ACT_TX_ACK: begin
        res.latency_ms = latency;
        cnt_nxt[cbts_pkg::CNT_ACK] = cnt_r[cbts_pkg::CNT_ACK] + 32'd1;
        if (latency > peak_r) begin
          peak_nxt = latency;
        end
        backoff_nxt = backoff_min_r;
      end
      cbts_pkg::ACT_EVENT_LOST, cbts_pkg::ACT_PROTO_ERR: begin
        cnt_nxt[cbts_pkg::CNT_PROTO] = cnt_r[cbts_pkg::CNT_PROTO] + 32'd1;
      end
      cbts_pkg::ACT_ERR_PASSIVE: begin
        cnt_nxt[cbts_pkg::CNT_PASSIVE] = cnt_r[cbts_pkg::CNT_PASSIVE] + 32'd1;
      end
      cbts_pkg::ACT_BUS_OFF: begin
        cnt_nxt[cbts_pkg::CNT_BUSOFF] = cnt_r[cbts_pkg::CNT_BUSOFF] + 32'd1;
        due_nxt     = now_r + {16'd0, backoff_r};
        pending_nxt = 1'b1;
        backoff_nxt = (dbl > {1'b0, backoff_max_r}) ? backoff_max_r : dbl[15:0];
      end
      default: begin
        due_nxt     = now_r + {16'd0, retry_delay_r};
        pending_nxt = 1'b1;
      end
    endcase
    wr.en                    = wr.en & commit;
    res.max_latency_ms       = peak_nxt;
    res.tx_count             = cnt_nxt[cbts_pkg::CNT_TX];
    res.tx_error_count       = cnt_nxt[cbts_pkg::CNT_TXERR];
    res.tx_ack_count         = cnt_nxt[cbts_pkg::CNT_ACK];
    res.protocol_error_count = cnt_nxt[cbts_pkg::CNT_PROTO];
    res.error_passive_count  = cnt_nxt[cbts_pkg::CNT_PASSIVE];
    res.bus_off_count        = cnt_nxt[cbts_pkg::CNT_BUSOFF];
    res.backoff_ms           = backoff_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backoff_min_r <= cbts_pkg::RST_BACKOFF_MIN;
      backoff_max_r <= cbts_pkg::RST_BACKOFF_MAX;
      retry_delay_r <= cbts_pkg::RST_RETRY_DELAY;
    end else if (cfg_we) begin
      case (cfg_addr)
        cbts_pkg::CFG_BACKOFF_MIN: backoff_min_r <= cfg_wdata;
        cbts_pkg::CFG_BACKOFF_MAX: backoff_max_r <= cfg_wdata;
        cbts_pkg::CFG_RETRY_DELAY: retry_delay_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r     <= '0;
      pending_r <= 1'b0;
      due_r     <= '0;
      backoff_r <= cbts_pkg::RST_BACKOFF_MIN;
      mark_r    <= '0;
      peak_r    <= '0;
      for (int i = 0; i < cbts_pkg::CNT_NUM; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (commit) begin
      now_r     <= now_nxt;
      pending_r <= pending_nxt;
      due_r     <= due_nxt;
      backoff_r <= backoff_nxt;
      mark_r    <= mark_nxt;
      peak_r    <= peak_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/can_tx_busoff_supervisor_top.sv @@
// Top level of the CAN transmit bus-off supervisor: input stage, stamp memory,
// execute stage and output register. Uses cbts_pkg, cbts_stamp_mem, cbts_exec.
//
//   Channel  Direction  Signals                               Transfer when
//   in       slave      in_tvalid in_tready in_tdata in_tuser in_tvalid & in_tready
//   out      master     out_tvalid out_tready out_tdata       out_tvalid & out_tready
//   cfg      write      cfg_we cfg_addr cfg_wdata             cfg_we
//
// One item is taken per cycle unless the output stalls.
// The stamp memory is read in the transfer cycle and written by the execute stage,
// with forwarding when a send and the next acknowledge hit the same entry.
// Reset clears all stamps at once through per-entry valid bits.
// A stalled output holds the execute stage, which in turn holds the input.
module can_tx_busoff_supervisor_top #(
  parameter int MARKER_COUNT = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // std_id[11:0], length[15:12], fifo_free[17:16], ack_marker[25:18], zeros above
  input  logic [31:0]  in_tdata,
  // action[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], marker[9:2], latency_ms[41:10], max_latency_ms[73:42],
  // recover_now[74], tx_count[106:75], tx_error_count[138:107],
  // tx_ack_count[170:139], protocol_error_count[202:171],
  // error_passive_count[234:203], bus_off_count[266:235], backoff_ms[282:267]
  output logic [287:0] out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata
);

  cbts_pkg::item_t   in_item;
  cbts_pkg::item_t   s1_item_r;
  cbts_pkg::result_t res;
  cbts_pkg::result_t out_res_r;
  cbts_pkg::wr_req_t wr;
  logic              s1_v_r;
  logic              out_v_r;
  logic              adv;
  logic              accept;
  logic [31:0]       stamp;

  assign in_item.action     = in_tuser;
  assign in_item.std_id     = in_tdata[11:0];
  assign in_item.length     = in_tdata[15:12];
  assign in_item.fifo_free  = in_tdata[17:16];
  assign in_item.ack_marker = in_tdata[25:18];

  assign adv       = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || adv;
  assign accept    = in_tvalid && in_tready;

  cbts_stamp_mem #(
    .MARKER_COUNT(MARKER_COUNT)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_marker(in_item.ack_marker),
    .wr       (wr),
    .stamp    (stamp)
  );

  cbts_exec #(
    .MARKER_COUNT(MARKER_COUNT)
  ) u_exec (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .commit   (adv),
    .item     (s1_item_r),
    .stamp    (stamp),
    .res      (res),
    .wr       (wr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_res_r};

endmodule

@@ rtl/core/cbts_checker.sv @@
// Port-level checks of the CAN transmit bus-off supervisor, bound to its top level.
// Depends only on the top level's ports.
module cbts_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [287:0] out_tdata
);

  a_idle_after_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  a_reject_no_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != 2'd0) |-> out_tdata[9:2] == 8'd0)
    else $error("rejected send carries a marker");

  a_recover_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[74] |->
      out_tdata[1:0] == 2'd0 && out_tdata[9:2] == 8'd0 && out_tdata[41:10] == 32'd0)
    else $error("recovery flag raised on a non-tick result");

endmodule

bind can_tx_busoff_supervisor_top cbts_checker u_cbts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
